FILE: design/pthcs_pkg.sv
// Shared types, constants and codes of the partition table hide/compact/sort block.
`default_nettype none

package pthcs_pkg;

  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  // Cell positions, covered counts and used counts share one width that also
  // holds the eight bit entry_count register.
  localparam int unsigned POS_W       = (CNT_W > 8) ? CNT_W : 8;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_HIDE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDE_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDE_END    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDE_TAG    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  entry_index;
    logic        entry_used;
    logic [63:0] entry_start;
    logic [63:0] entry_end;
    logic [15:0] entry_tag;
  } pthcs_in_t;

  typedef struct packed {
    logic        read_used;
    logic [63:0] read_start;
    logic [63:0] read_end;
    logic [15:0] read_tag;
    logic [7:0]  used_count;
  } pthcs_out_t;

  typedef struct packed {
    logic        used;
    logic [63:0] first;
    logic [63:0] last;
    logic [15:0] tag;
  } slot_t;

  // Walks the chain one cell per cycle during a filter or count pass.
  typedef struct packed {
    logic             valid;
    logic             placed;
    logic [POS_W-1:0] count;
  } token_t;

  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] index;
    slot_t            wr_slot;
    slot_t            hide;
    logic             filter;
    logic             sort;
    logic             phase;
    logic [POS_W-1:0] n;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FILTER = 5'b00010,
    ST_SORT   = 5'b00100,
    ST_RESULT = 5'b01000,
    ST_COUNT  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: design/pthcs_cell.sv
// One table slot of the chain: load, hide filter, used count and odd-even sort step.
`default_nettype none

module pthcs_cell import pthcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [POS_W-1:0] pos_i,
  input  cell_ctrl_t       ctrl_i,
  input  slot_t            left_i,
  input  slot_t            right_i,
  input  logic             swap_l_i,
  input  token_t           tok_i,
  output slot_t            slot_o,
  output logic             swap_r_o,
  output token_t           tok_o
);

  logic             used_q, used_d;
  logic [63:0]      first_q, first_d;
  logic [63:0]      last_q, last_d;
  logic [15:0]      tag_q, tag_d;
  logic             tok_valid_q;
  logic             tok_placed_q, tok_placed_d;
  logic [POS_W-1:0] tok_count_q, tok_count_d;

  logic             covered;
  logic [POS_W-1:0] nxt_pos;
  logic             meet;
  logic             hit;
  logic             survive;
  logic             clear;
  logic             wr;
  slot_t            slot_d;

  assign slot_o = '{used: used_q, first: first_q, last: last_q, tag: tag_q};
  assign tok_o  = '{valid: tok_valid_q, placed: tok_placed_q, count: tok_count_q};

  always_comb begin
    covered = pos_i < ctrl_i.n;
    nxt_pos = pos_i + POS_W'(1);
    // Inclusive ranges overlap.
    meet    = (first_q < ctrl_i.hide.first) ? (last_q >= ctrl_i.hide.first)
                                            : (first_q <= ctrl_i.hide.last);
    hit     = tok_i.valid && covered && ctrl_i.filter && used_q && meet;
    survive = tok_i.valid && covered && used_q && !(hit && tok_i.placed);
    clear   = tok_i.valid && covered && ctrl_i.filter && (!used_q || (hit && tok_i.placed));
    wr      = ctrl_i.load && (ctrl_i.index == pos_i);
    // Unused slots sort as if their key were infinite, so the sort also compacts.
    swap_r_o = ctrl_i.sort && (pos_i[0] == ctrl_i.phase) && (nxt_pos < ctrl_i.n) &&
               right_i.used && (!used_q || (first_q > right_i.first));

    priority if (wr) begin
      slot_d = ctrl_i.wr_slot;
    end else if (swap_r_o) begin
      slot_d = right_i;
    end else if (swap_l_i) begin
      slot_d = left_i;
    end else if (clear) begin
      slot_d = '0;
    end else if (hit) begin
      slot_d = ctrl_i.hide;
    end else begin
      slot_d = slot_o;
    end

    used_d       = slot_d.used;
    first_d      = slot_d.first;
    last_d       = slot_d.last;
    tag_d        = slot_d.tag;
    tok_placed_d = tok_i.placed | hit;
    tok_count_d  = tok_i.count + POS_W'(survive);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    last_q       <= last_d;
    tag_q        <= tag_d;
    tok_placed_q <= tok_placed_d;
    tok_count_q  <= tok_count_d;
  end

endmodule

`default_nettype wire

FILE: design/partition_table_hide_compact_sort.sv
// Top level of the partition table with hide, compact and sort over a chain of slot cells.
//
//   channel  direction  handshake                payload
//   in       request    in_valid_i / in_stall_o   in_data_i  (pthcs_in_t)
//   out      result     out_valid_o / out_stall_i out_data_o (pthcs_out_t)
//   cfg      write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Load, read and unknown commands may follow back to back unless the output or a recount stalls.
// For a hide request a token walks the cell chain once for the filter, then MAX_ENTRIES
// odd-even transposition steps sort.
// A write of entry_count stalls requests while a token recounts.
// Reset clears all used flags, the used count and the registers to their defaults.
// A result waits in the output register while out_stall_i is high; requests stall meanwhile.
`default_nettype none

module partition_table_hide_compact_sort import pthcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pthcs_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pthcs_out_t           out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  state_e           state_q, state_d;
  logic             go_q, go_d;
  logic             pending_q, pending_d;
  logic [POS_W-1:0] ctr_q, ctr_d;
  logic [POS_W-1:0] count_q, count_d;
  logic [7:0]       entry_count_q;
  logic [63:0]      hide_start_q;
  logic [63:0]      hide_end_q;
  logic [15:0]      hide_tag_q;
  logic             out_valid_q;
  pthcs_out_t       out_q, out_d;

  logic             in_ready;
  logic             accept;
  logic             out_free;
  logic             cfg_we;
  logic [POS_W-1:0] n;
  logic [POS_W-1:0] ec_ext;
  logic [POS_W-1:0] idx_ext;
  logic [POS_W-1:0] cnt_load;
  slot_t            rd;
  cell_ctrl_t       ctrl;
  token_t           tok_first;
  token_t           tok_last;

  slot_t            slot_vec [MAX_ENTRIES];
  logic             swap_vec [MAX_ENTRIES];
  token_t           tok_vec  [MAX_ENTRIES];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign ec_ext  = POS_W'(entry_count_q);
  assign n       = (ec_ext > POS_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : ec_ext;
  assign idx_ext = POS_W'(in_data_i.entry_index);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_ready   = (state_q == ST_IDLE) && !pending_q && out_free;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;

  // Slot addressed by the request; no cell matches an index beyond the table.
  always_comb begin
    rd = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (idx_ext == POS_W'(i)) begin
        rd = rd | slot_vec[i];
      end
    end
  end

  assign cnt_load = (idx_ext < n) ? (count_q + POS_W'(in_data_i.entry_used) - POS_W'(rd.used))
                                  : count_q;

  assign ctrl = '{
    load:    accept && (in_data_i.cmd == CMD_LOAD),
    index:   idx_ext,
    wr_slot: '{used: in_data_i.entry_used, first: in_data_i.entry_start,
               last: in_data_i.entry_end, tag: in_data_i.entry_tag},
    hide:    '{used: 1'b1, first: hide_start_q, last: hide_end_q, tag: hide_tag_q},
    filter:  state_q == ST_FILTER,
    sort:    state_q == ST_SORT,
    phase:   ctr_q[0],
    n:       n
  };

  assign tok_first = '{valid: go_q, placed: 1'b0, count: '0};
  assign tok_last  = tok_vec[MAX_ENTRIES-1];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    slot_t  left_s;
    slot_t  right_s;
    logic   swap_l;
    token_t tok_in;

    if (g == 0) begin : g_head
      assign left_s = '0;
      assign swap_l = 1'b0;
      assign tok_in = tok_first;
    end else begin : g_body
      assign left_s = slot_vec[g-1];
      assign swap_l = swap_vec[g-1];
      assign tok_in = tok_vec[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_next
      assign right_s = slot_vec[g+1];
    end

    pthcs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .pos_i    (POS_W'(g)),
      .ctrl_i   (ctrl),
      .left_i   (left_s),
      .right_i  (right_s),
      .swap_l_i (swap_l),
      .tok_i    (tok_in),
      .slot_o   (slot_vec[g]),
      .swap_r_o (swap_vec[g]),
      .tok_o    (tok_vec[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    go_d      = 1'b0;
    pending_d = pending_q;
    ctr_d     = ctr_q;
    count_d   = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pending_q) begin
          go_d      = 1'b1;
          pending_d = 1'b0;
          state_d   = ST_COUNT;
        end else if (accept) begin
          if (in_data_i.cmd == CMD_HIDE) begin
            go_d    = 1'b1;
            state_d = ST_FILTER;
          end else if (in_data_i.cmd == CMD_LOAD) begin
            count_d = cnt_load;
          end
        end
      end
      ST_FILTER: begin
        if (tok_last.valid) begin
          count_d = tok_last.count;
          ctr_d   = '0;
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        ctr_d = ctr_q + POS_W'(1);
        if (ctr_q == POS_W'(MAX_ENTRIES - 1)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (tok_last.valid) begin
          count_d = tok_last.count;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A new covered count always calls for a fresh recount.
    if (cfg_we && (cfg_index_i == CFG_ENTRY_COUNT)) begin
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      pending_q <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      go_q      <= go_d;
      pending_q <= pending_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q <= ctr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 8'd128;
      hide_start_q  <= '0;
      hide_end_q    <= '0;
      hide_tag_q    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[7:0];
        CFG_HIDE_START:  hide_start_q  <= cfg_data_i;
        CFG_HIDE_END:    hide_end_q    <= cfg_data_i;
        CFG_HIDE_TAG:    hide_tag_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && (in_data_i.cmd != CMD_HIDE)) begin
      out_valid_q <= 1'b1;
    end else if ((state_q == ST_RESULT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d = out_q;
    if (accept && (in_data_i.cmd != CMD_HIDE)) begin
      out_d = '0;
      if (in_data_i.cmd == CMD_READ) begin
        out_d.read_used  = rd.used;
        out_d.read_start = rd.first;
        out_d.read_end   = rd.last;
        out_d.read_tag   = rd.tag;
      end
      out_d.used_count = (in_data_i.cmd == CMD_LOAD) ? cnt_load[7:0] : count_q[7:0];
    end else if ((state_q == ST_RESULT) && out_free) begin
      out_d            = '0;
      out_d.used_count = count_q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  logic [MAX_ENTRIES-1:0] used_vec;
  logic [MAX_ENTRIES-1:0] cov_vec;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      used_vec[i] = slot_vec[i].used;
      cov_vec[i]  = POS_W'(i) < n;
    end
  end

  // The used count can never exceed the table.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= POS_W'(MAX_ENTRIES))
    else $error("used count beyond table size");

  // The walking token leaves the chain only during a filter or count pass.
  a_token_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.valid |-> ((state_q == ST_FILTER) || (state_q == ST_COUNT)))
    else $error("token left the chain outside a pass");

  // After sorting, the used slots of the covered range form a prefix.
  a_sorted_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |->
      ((used_vec[MAX_ENTRIES-1:1] & ~used_vec[MAX_ENTRIES-2:0] &
        cov_vec[MAX_ENTRIES-1:1]) == '0))
    else $error("used slots not compacted after sort");

  // A new entry_count always leads to a recount.
  a_recount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_index_i == CFG_ENTRY_COUNT)) |=> pending_q)
    else $error("entry_count write did not request a recount");
`endif

endmodule

`default_nettype wire
